// ===== hdl/swv_pkg.sv =====
// Shared types, constants and saturation helpers for the square-wave voltammetry sequencer.
`default_nettype none
package swv_pkg;

    localparam int POT_W   = 20;
    localparam int AMP_W   = 19;
    localparam int CUR_W   = 32;
    localparam int PHASE_W = 32;
    localparam int IDX_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr ADDR_START = 4'h0;
    localparam t_addr ADDR_STEP  = 4'h4;
    localparam t_addr ADDR_AMP   = 4'h8;
    localparam t_addr ADDR_INC   = 4'hC;

    localparam logic signed [POT_W-1:0] POT_MAX = 20'sh7FFFF;
    localparam logic signed [POT_W-1:0] POT_MIN = 20'sh80000;
    localparam logic signed [CUR_W-1:0] CUR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CUR_W-1:0] CUR_MIN = 32'sh8000_0000;
    localparam logic [IDX_W-1:0]        IDX_MAX = 16'hFFFF;
    localparam logic [1:0]              FILL_FULL = 2'd3;
    localparam logic [1:0]              FILL_PEAK = 2'd2;

    typedef struct packed {
        logic signed [POT_W-1:0] start;
        logic signed [POT_W-1:0] step;
        logic [AMP_W-1:0]        amp;
        logic [PHASE_W-1:0]      inc;
    } t_cfg;

    typedef struct packed {
        logic signed [POT_W-1:0] base;
        logic [PHASE_W-1:0]      phase;
        logic                    half_now;
        logic                    half_next;
        logic signed [CUR_W-1:0] held;
        logic [IDX_W-1:0]        count;
        logic signed [CUR_W-1:0] hist0;
        logic signed [CUR_W-1:0] hist1;
        logic [1:0]              fill;
    } t_state;

    typedef struct packed {
        logic signed [POT_W-1:0] applied_potential;
        logic                    record_valid;
        logic signed [CUR_W-1:0] difference_current;
        logic signed [CUR_W-1:0] forward_current;
        logic signed [POT_W-1:0] recorded_base;
        logic [IDX_W-1:0]        period_index;
        logic                    peak_found;
    } t_result;

    // Clamp a one-bit-grown potential back into 20 bits.
    function automatic logic signed [POT_W-1:0] sat_pot(input logic signed [POT_W:0] v);
        logic signed [POT_W-1:0] r;
        if (v[POT_W] != v[POT_W-1]) begin
            r = v[POT_W] ? POT_MIN : POT_MAX;
        end else begin
            r = v[POT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [CUR_W:0] v);
        logic signed [CUR_W-1:0] r;
        if (v[CUR_W] != v[CUR_W-1]) begin
            r = v[CUR_W] ? CUR_MIN : CUR_MAX;
        end else begin
            r = v[CUR_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/swv_cfg.sv =====
// APB-style configuration register file for the sequencer.
`default_nettype none
module swv_cfg
    import swv_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr)
                ADDR_START: n_cfg.start = pwdata[POT_W-1:0];
                ADDR_STEP:  n_cfg.step  = pwdata[POT_W-1:0];
                ADDR_AMP:   n_cfg.amp   = pwdata[AMP_W-1:0];
                ADDR_INC:   n_cfg.inc   = pwdata[PHASE_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr)
            ADDR_START: prdata = {{(DATA_W-POT_W){1'b0}}, r_cfg.start};
            ADDR_STEP:  prdata = {{(DATA_W-POT_W){1'b0}}, r_cfg.step};
            ADDR_AMP:   prdata = {{(DATA_W-AMP_W){1'b0}}, r_cfg.amp};
            ADDR_INC:   prdata = r_cfg.inc;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hdl/swv_step.sv =====
// Next-state and result logic for one tick of the square-wave sequencer.
`default_nettype none
module swv_step
    import swv_pkg::*;
(
    input  wire t_cfg               i_cfg,
    input  wire t_state             i_state,
    input  wire logic               i_restart,
    input  wire logic signed [CUR_W-1:0] i_current_sample,
    output t_state                  o_state,
    output t_result                 o_result
);

    logic signed [POT_W:0]   base_sum;
    logic signed [POT_W-1:0] base_n;
    logic signed [POT_W:0]   base_x;
    logic signed [POT_W:0]   amp_x;
    logic signed [POT_W-1:0] applied;
    logic [PHASE_W-1:0]      phase_n;
    logic                    hn;
    logic                    hx;
    logic                    hold;
    logic                    rec;
    logic signed [CUR_W-1:0] held;
    logic signed [CUR_W-1:0] h0;
    logic signed [CUR_W-1:0] h1;
    logic signed [CUR_W-1:0] diff;
    logic                    peak;

    assign held = i_state.held;
    assign h0   = i_state.hist0;
    assign h1   = i_state.hist1;

    assign base_sum = {i_state.base[POT_W-1], i_state.base} + {i_cfg.step[POT_W-1], i_cfg.step};
    assign amp_x    = $signed({2'b00, i_cfg.amp});

    always_comb begin
        if (i_restart) begin
            base_n  = i_cfg.start;
            phase_n = '0;
            hn      = 1'b1;
            hx      = 1'b1;
        end else begin
            // Step the staircase on the tick after a low-to-high boundary.
            base_n  = (!i_state.half_now && i_state.half_next) ? sat_pot(base_sum)
                                                               : i_state.base;
            phase_n = i_state.phase + i_cfg.inc;
            hn      = i_state.half_next;
            hx      = !phase_n[PHASE_W-1];
        end
    end

    assign base_x = {base_n[POT_W-1], base_n};

    always_comb begin
        if (i_restart) begin
            applied = base_n;
        end else if (hn) begin
            applied = sat_pot(base_x + amp_x);
        end else begin
            applied = sat_pot(base_x - amp_x);
        end
    end

    assign hold = hn && !hx;
    assign rec  = !hn && hx;
    assign diff = sat_cur({held[CUR_W-1], held} - {i_current_sample[CUR_W-1], i_current_sample});
    assign peak = (i_state.fill >= FILL_PEAK) && (h0 > diff) && (h0 > h1);

    always_comb begin
        o_state           = i_state;
        o_state.base      = base_n;
        o_state.phase     = phase_n;
        o_state.half_now  = hn;
        o_state.half_next = hx;
        if (hold) begin
            o_state.held = i_current_sample;
        end
        if (rec) begin
            o_state.hist0 = diff;
            o_state.hist1 = h0;
            o_state.fill  = (i_state.fill == FILL_FULL) ? FILL_FULL : i_state.fill + 2'd1;
            o_state.count = (i_state.count == IDX_MAX) ? IDX_MAX : i_state.count + 16'd1;
        end
    end

    always_comb begin
        o_result                   = '0;
        o_result.applied_potential = applied;
        if (rec) begin
            o_result.record_valid       = 1'b1;
            o_result.difference_current = diff;
            o_result.forward_current    = held;
            o_result.recorded_base      = base_n;
            o_result.period_index       = i_state.count;
            o_result.peak_found         = peak;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/square_wave_voltammetry_sequencer.sv =====
// Top level of the square-wave voltammetry sequencer.
// Input channel: i_valid / o_stall carry one tick word (restart flag and measured
// current). Output channel: o_valid / i_stall carry one result word per tick: the
// potential to apply and, on a low-to-high boundary, a period record (difference
// and forward current, base potential, period index, peak flag).
// The user must write configuration through the APB-style port only while the block
// is idle; the block itself does not enforce this. A taken word lands in the input
// register, then moves to the result register (which drives the outputs) when that is
// free or being drained. Throughput: one word per clock while the receiver does not stall;
// the sequencer state is updated with a single pass of add, saturate and compare logic
// between the two registers. Reset clears configuration and both valid flags, resets
// sequencer state, and the base potential starts at zero until a restart word loads the
// start potential. When the receiver stalls, the result word holds; the input register
// keeps taking words until it too is full, then o_stall rises.
`default_nettype none
module square_wave_voltammetry_sequencer
    import swv_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_restart,
    input  wire logic signed [CUR_W-1:0] i_current_sample,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [POT_W-1:0]      o_applied_potential,
    output logic                         o_record_valid,
    output logic signed [CUR_W-1:0]      o_difference_current,
    output logic signed [CUR_W-1:0]      o_forward_current,
    output logic signed [POT_W-1:0]      o_recorded_base,
    output logic [IDX_W-1:0]             o_period_index,
    output logic                         o_peak_found,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    t_result r_out;
    logic    r_out_valid;
    logic    r_in_valid;
    logic    r_restart;
    logic signed [CUR_W-1:0] r_cur;
    logic    advance;
    logic    in_load;

    swv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    swv_step u_step (
        .i_cfg            (cfg),
        .i_state          (r_state),
        .i_restart        (r_restart),
        .i_current_sample (r_cur),
        .o_state          (n_state),
        .o_result         (n_out)
    );

    // Move the held word on whenever the result register is free or being drained.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_load = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_restart <= i_restart;
            r_cur     <= i_current_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{half_now: 1'b1, half_next: 1'b1, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_applied_potential  = r_out.applied_potential;
    assign o_record_valid       = r_out.record_valid;
    assign o_difference_current = r_out.difference_current;
    assign o_forward_current    = r_out.forward_current;
    assign o_recorded_base      = r_out.recorded_base;
    assign o_period_index       = r_out.period_index;
    assign o_peak_found         = r_out.peak_found;

endmodule
`default_nettype wire

// ===== hdl/swv_checker.sv =====
// Port-level checks for the square-wave voltammetry sequencer, bound to the top level.
`default_nettype none
module swv_checker
    import swv_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_stall,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic signed [POT_W-1:0] o_applied_potential,
    input wire logic                    o_record_valid,
    input wire logic signed [CUR_W-1:0] o_difference_current,
    input wire logic signed [CUR_W-1:0] o_forward_current,
    input wire logic signed [POT_W-1:0] o_recorded_base,
    input wire logic [IDX_W-1:0]        o_period_index,
    input wire logic                    o_peak_found
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_applied_potential)
            && $stable(o_record_valid) && $stable(o_difference_current))
        else $error("result word changed while stalled");

    // Record fields stay clear on ticks without a record.
    a_no_rec_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_record_valid |-> o_difference_current == '0
            && o_forward_current == '0 && o_recorded_base == '0
            && o_period_index == '0 && !o_peak_found)
        else $error("record fields set without a record");

    a_peak_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_peak_found |-> o_record_valid)
        else $error("peak flagged outside a record");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid straight after reset");

endmodule

bind square_wave_voltammetry_sequencer swv_checker u_swv_checker (.*);
`default_nettype wire

// ===== tb/tb_square_wave_voltammetry_sequencer.sv =====
// Self-checking testbench: square-wave voltammetry sequencer against a cycle-free predictor.
`timescale 1ns / 1ps
module tb_square_wave_voltammetry_sequencer
    import swv_pkg::*;
();

    localparam int unsigned NUM_ROWS     = 32;
    localparam int unsigned RANDOM_TICKS = 750;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned PRINT_CAP    = 40;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               restart;
        logic [CUR_W-1:0]   current;
        t_addr              addr;
        logic [DATA_W-1:0]  data;
        logic               typed;
        logic [POT_W-1:0]   pot;
    } t_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_restart;
    logic signed [CUR_W-1:0] i_current_sample;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [POT_W-1:0] o_applied_potential;
    logic                    o_record_valid;
    logic signed [CUR_W-1:0] o_difference_current;
    logic signed [CUR_W-1:0] o_forward_current;
    logic signed [POT_W-1:0] o_recorded_base;
    logic [IDX_W-1:0]        o_period_index;
    logic                    o_peak_found;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    square_wave_voltammetry_sequencer dut (.*);

    // Register copies and sequencer state of the predictor
    logic signed [POT_W-1:0] set_start;
    logic signed [POT_W-1:0] set_step;
    logic [AMP_W-1:0]        set_amp;
    logic [PHASE_W-1:0]      set_inc;
    logic signed [POT_W-1:0] wave_base;
    logic [PHASE_W-1:0]      wave_phase;
    logic                    wave_high_now;
    logic                    wave_high_next;
    logic signed [CUR_W-1:0] wave_forward;
    logic [IDX_W-1:0]        wave_period;
    logic signed [CUR_W-1:0] wave_diffs [3];
    int unsigned             wave_fill;

    t_result     due_outputs [$];
    int unsigned fault_count    = 0;
    int unsigned ticks_sent     = 0;
    int unsigned records_seen   = 0;
    int unsigned peaks_seen     = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_pace      = 2;
    int unsigned recv_pace      = 2;
    int unsigned recv_hold      = 0;

    t_row directed_rows [NUM_ROWS] = '{
        // before any restart, registers at reset
        '{ROW_TICK, 1'b0, 32'h7FFF_FFFF, ADDR_START, 32'h0000_0000, 1'b1, 20'h00000},
        '{ROW_TICK, 1'b1, 32'h8000_0000, ADDR_START, 32'h0000_0000, 1'b1, 20'h00000},
        // top extremes, wave toggling every tick
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_START, 32'h0007_FFFF, 1'b0, 20'h00000},
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_STEP,  32'h0007_FFFF, 1'b0, 20'h00000},
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_AMP,   32'hFFFF_FFFF, 1'b0, 20'h00000},
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_INC,   32'h8000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b1, 32'h0000_0005, ADDR_START, 32'h0000_0000, 1'b1, 20'h7FFFF},
        '{ROW_TICK, 1'b0, 32'h7FFF_FFFF, ADDR_START, 32'h0000_0000, 1'b1, 20'h7FFFF},
        '{ROW_TICK, 1'b0, 32'h8000_0000, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0064, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_000A, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_03E8, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0000, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0014, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0000, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        // restart mid-scan keeps count and history
        '{ROW_TICK, 1'b1, 32'hFFFF_FFFF, ADDR_START, 32'h0000_0000, 1'b1, 20'h7FFFF},
        // bottom extremes
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_START, 32'h0008_0000, 1'b0, 20'h00000},
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_STEP,  32'hFFF8_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b1, 32'h0000_0000, ADDR_START, 32'h0000_0000, 1'b1, 20'h80000},
        '{ROW_TICK, 1'b0, 32'h8000_0000, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h7FFF_FFFF, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0001, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0002, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        // frozen wave, then the slowest possible wave
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_AMP,   32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_INC,   32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h1234_5678, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h8765_4321, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_CFG,  1'b0, 32'h0000_0000, ADDR_INC,   32'hFFFF_FFFF, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b1, 32'h0000_0000, ADDR_START, 32'h0000_0000, 1'b1, 20'h80000},
        '{ROW_TICK, 1'b0, 32'hFFFF_FFFF, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'h0000_0001, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000},
        '{ROW_TICK, 1'b0, 32'hAAAA_5555, ADDR_START, 32'h0000_0000, 1'b0, 20'h00000}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_wave();
        set_start      = '0;
        set_step       = '0;
        set_amp        = '0;
        set_inc        = '0;
        wave_base      = '0;
        wave_phase     = '0;
        wave_high_now  = 1'b1;
        wave_high_next = 1'b1;
        wave_forward   = '0;
        wave_period    = '0;
        wave_diffs     = '{default: '0};
        wave_fill      = 0;
    endfunction

    // Work out the result word of one tick and advance the wave
    function automatic t_result advance_wave(input logic restart,
                                             input logic signed [CUR_W-1:0] current);
        t_result r;
        longint  pot;
        longint  diff;
        r = '0;
        if (restart) begin
            wave_base      = set_start;
            wave_phase     = '0;
            wave_high_now  = 1'b1;
            wave_high_next = 1'b1;
            pot            = longint'(wave_base);
        end else begin
            if (!wave_high_now && wave_high_next) begin
                wave_base = POT_W'(clamp(longint'(wave_base) + longint'(set_step),
                                         longint'(POT_MIN), longint'(POT_MAX)));
            end
            wave_high_now  = wave_high_next;
            wave_phase     = wave_phase + set_inc;
            wave_high_next = !wave_phase[PHASE_W-1];
            pot = wave_high_now ? longint'(wave_base) + longint'(set_amp)
                                : longint'(wave_base) - longint'(set_amp);
        end
        r.applied_potential = POT_W'(clamp(pot, longint'(POT_MIN), longint'(POT_MAX)));
        if (wave_high_now && !wave_high_next) begin
            wave_forward = current;
        end else if (!wave_high_now && wave_high_next) begin
            diff = clamp(longint'(wave_forward) - longint'(current),
                         longint'(CUR_MIN), longint'(CUR_MAX));
            wave_diffs[2] = wave_diffs[1];
            wave_diffs[1] = wave_diffs[0];
            wave_diffs[0] = CUR_W'(diff);
            if (wave_fill < 3) wave_fill++;
            r.record_valid       = 1'b1;
            r.difference_current = CUR_W'(diff);
            r.forward_current    = wave_forward;
            r.recorded_base      = wave_base;
            r.period_index       = wave_period;
            r.peak_found         = wave_fill >= 3 && wave_diffs[1] > wave_diffs[0] &&
                                   wave_diffs[1] > wave_diffs[2];
            if (wave_period != IDX_MAX) wave_period++;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] reg_mask(input t_addr addr);
        case (addr)
            ADDR_START, ADDR_STEP: return 32'h000F_FFFF;
            ADDR_AMP:              return 32'h0007_FFFF;
            default:               return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic int unsigned draw_wait(input int unsigned pace);
        if (pace == 0) return 0;
        if (pace == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [CUR_W-1:0] pick_current();
        case ($urandom_range(0, 9))
            0:       return CUR_MAX;
            1:       return CUR_MIN;
            2, 3:    return 32'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(input string label, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            fault_count++;
            if (fault_count <= PRINT_CAP) begin
                $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            end
        end
    endfunction

    task automatic write_reg(input t_addr addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] mask;
        mask = reg_mask(addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // read the register straight back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (((prdata ^ data) & mask) != '0) begin
            fault_count++;
            if (fault_count <= PRINT_CAP) begin
                $display("%0t: register at %h expected %h, got %h", $time, addr,
                         data & mask, prdata & mask);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (addr)
            ADDR_START: set_start = data[POT_W-1:0];
            ADDR_STEP:  set_step  = data[POT_W-1:0];
            ADDR_AMP:   set_amp   = data[AMP_W-1:0];
            ADDR_INC:   set_inc   = data;
            default: ;
        endcase
    endtask

    task automatic pick_settings();
        logic [DATA_W-1:0] start_word;
        logic [DATA_W-1:0] step_word;
        logic [DATA_W-1:0] amp_word;
        logic [DATA_W-1:0] inc_word;
        case ($urandom_range(0, 3))
            0:       start_word = 32'h0007_FFFF;
            1:       start_word = 32'h0008_0000;
            default: start_word = $urandom;
        endcase
        step_word = ($urandom_range(0, 3) == 0) ? $urandom
                                                : 32'($urandom_range(0, 8191)) - 32'd4096;
        amp_word  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 4095));
        case ($urandom_range(0, 7))
            0:       inc_word = '0;
            1:       inc_word = '1;
            2:       inc_word = $urandom;
            default: inc_word = $urandom_range(32'h1000_0000, 32'h8000_0000);
        endcase
        write_reg(ADDR_START, start_word);
        write_reg(ADDR_STEP, step_word);
        write_reg(ADDR_AMP, amp_word);
        write_reg(ADDR_INC, inc_word);
    endtask

    task automatic send_tick(input logic restart, input logic signed [CUR_W-1:0] current,
                             input logic typed, input logic [POT_W-1:0] typed_pot);
        int unsigned gap;
        t_result     want;
        ticks_sent++;
        if (ticks_sent % 64 == 0) send_pace = $urandom_range(0, 2);
        gap = draw_wait(send_pace);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_restart        <= restart;
        i_current_sample <= current;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        want = advance_wave(restart, current);
        if (typed) begin
            want                   = '0;
            want.applied_potential = typed_pot;
        end
        due_outputs.push_back(want);
    endtask

    // Drop valid and wait until every result word is back
    task automatic settle();
        i_valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_output();
        t_result want;
        if (due_outputs.size() == 0) begin
            fault_count++;
            if (fault_count <= PRINT_CAP) begin
                $display("%0t: result word expected none, got potential %0d", $time,
                         o_applied_potential);
            end
        end else begin
            want = due_outputs.pop_front();
            check_field("applied_potential", 64'(want.applied_potential),
                        64'(o_applied_potential));
            check_field("record_valid", 64'(want.record_valid), 64'(o_record_valid));
            check_field("difference_current", 64'(want.difference_current),
                        64'(o_difference_current));
            check_field("forward_current", 64'(want.forward_current), 64'(o_forward_current));
            check_field("recorded_base", 64'(want.recorded_base), 64'(o_recorded_base));
            check_field("period_index", 64'(want.period_index), 64'(o_period_index));
            check_field("peak_found", 64'(want.peak_found), 64'(o_peak_found));
            if (want.record_valid) begin
                records_seen++;
                if (want.peak_found) peaks_seen++;
            end
        end
    endtask

    // Receiver: take words, then hold off for a drawn number of cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_output();
            results_seen++;
            if (results_seen % 64 == 0) recv_pace = $urandom_range(0, 2);
            recv_hold = draw_wait(recv_pace);
        end else if (recv_hold != 0) begin
            recv_hold--;
        end
        i_stall <= (recv_hold != 0);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        int unsigned seg_len;
        int unsigned random_ticks;
        random_ticks = 0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_restart        <= 1'b0;
        i_current_sample <= '0;
        i_stall          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        clear_wave();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[n].addr, directed_rows[n].data);
            end else begin
                send_tick(directed_rows[n].restart, directed_rows[n].current,
                          directed_rows[n].typed, directed_rows[n].pot);
            end
        end

        // Scans with random settings; mostly opened by a restart, a few broken
        while (random_ticks < RANDOM_TICKS) begin
            settle();
            pick_settings();
            seg_len = $urandom_range(30, 90);
            for (k = 0; k < seg_len; k++) begin
                send_tick((k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0),
                          pick_current(), 1'b0, '0);
                random_ticks++;
            end
        end
        settle();

        $display("Sent %0d tick words over directed edge cases and random scans.",
                 ticks_sent);
        $display("%0d period records checked, %0d flagged a peak.", records_seen, peaks_seen);
        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== square_wave_voltammetry_sequencer.f =====
hdl/swv_pkg.sv
hdl/swv_cfg.sv
hdl/swv_step.sv
hdl/square_wave_voltammetry_sequencer.sv
hdl/swv_checker.sv
tb/tb_square_wave_voltammetry_sequencer.sv
